[rtl/aet_pkg.sv]
// aet_pkg: operation codes, status codes and controller states of the
// aging endpoint table. No dependencies; imported by the top level.
package aet_pkg;

   typedef enum logic [1:0] {
      OP_UPDATE   = 2'd0,
      OP_REMOVE   = 2'd1,
      OP_CULL     = 2'd2,
      OP_RESERVED = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_REFRESHED = 3'd0,
      ST_INSERTED  = 3'd1,
      ST_DROPPED   = 3'd2,
      ST_REMOVED   = 3'd3,
      ST_NOT_FOUND = 3'd4,
      ST_CULLED    = 3'd5
   } status_type;

   typedef enum logic [2:0] {
      FSM_CLEAR,
      FSM_IDLE,
      FSM_SCAN,
      FSM_LAST,
      FSM_COMMIT,
      FSM_DONE
   } fsm_type;

   localparam logic [15:0] LIFETIME_RESET = 16'd300;

   // entry word layout below the key, from the lsb up
   localparam int STAMP_W = 32;
   localparam int FLAGS_W = 2;
   localparam int PORT_W  = 16;

endpackage

[rtl/aging_endpoint_table.sv]
// aging_endpoint_table: endpoint table with per-entry aging, kept in one ram.
// Depends on aet_pkg and aet_ram.
//
// usage
//  - req_ channel carries one operation: update/insert, remove or cull;
//    the key is ip version, the low ADDRESS_BYTES of the address and the port
//  - rsp_ channel returns one result per operation: status, affected count
//    and occupancy after the operation
//  - csr_ channel writes the lifetime in seconds; it is always ready and
//    should be written only while no operation is in flight
//  - every operation but a reserved code scans all CAPACITY entries through
//    the single ram read port, one entry per cycle, then commits its result
//    and loads it into the output register; a reserved operation code skips
//    the scan and goes straight to the commit
//  - inserts and refreshes are written back after the scan, removals and
//    culls are written back behind the read, in the cycle after each read
//  - after reset the block sweeps the ram once to clear the valid bits,
//    holding req_stall high; csr_ writes are taken meanwhile
//  - the result sits in an output register, so the next request transfers in
//    while a stalled result waits; a finished operation holds until that
//    register is free, and rsp_ payload stays stable under rsp_stall
module aging_endpoint_table import aet_pkg::*; #(
   parameter int CAPACITY      = 64,
   parameter int ADDRESS_BYTES = 16
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_operation,
   input  logic        req_ip_version,
   input  logic [63:0] req_address_high,
   input  logic [63:0] req_address_low,
   input  logic [15:0] req_port_number,
   input  logic        req_is_empty,
   input  logic        req_is_full,
   input  logic [31:0] req_now_seconds,
   // response channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_status,
   output logic [6:0]  rsp_affected_count,
   output logic [6:0]  rsp_occupancy,
   // configuration channel
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_lifetime_seconds
);

   localparam int KW        = ADDRESS_BYTES * 8;
   localparam int AW        = $clog2(CAPACITY);
   localparam int CW        = $clog2(CAPACITY + 1);
   localparam int FLAGS_LSB = STAMP_W;
   localparam int PORT_LSB  = FLAGS_LSB + FLAGS_W;
   localparam int ADDR_LSB  = PORT_LSB + PORT_W;
   localparam int VER_BIT   = ADDR_LSB + KW;
   localparam int VALID_BIT = VER_BIT + 1;
   localparam int WW        = VALID_BIT + 1;

   localparam logic [AW-1:0] LAST_IDX  = AW'(CAPACITY - 1);
   localparam logic [CW-1:0] CAP_COUNT = CW'(CAPACITY);

   // controller
   fsm_type state_ff, state_in;
   logic    req_xfer;
   logic    rsp_free;
   logic    rsp_load;
   logic    scan_rd;
   logic    cnt_step;
   logic    commit;

   // request latch
   op_type           op_ff;
   logic             ver_ff;
   logic [KW-1:0]    key_ff;
   logic [15:0]      port_ff;
   logic [1:0]       flags_ff;
   logic [31:0]      now_ff;
   logic [127:0]     req_address;

   // scan state
   logic [AW-1:0] cnt_ff, cnt_in;
   logic          rd_vld_ff;
   logic [AW-1:0] idx_ff;
   logic          match_found_ff, match_found_in;
   logic [AW-1:0] match_idx_ff, match_idx_in;
   logic [1:0]    match_flags_ff, match_flags_in;
   logic          free_found_ff, free_found_in;
   logic [AW-1:0] free_idx_ff, free_idx_in;
   logic [CW-1:0] aff_ff, aff_in;
   logic [CW-1:0] occ_ff, occ_in;

   // result
   status_type    res_status_ff, res_status_in;
   logic [CW-1:0] res_aff_ff, res_aff_in;
   logic          rsp_valid_ff, rsp_valid_in;
   status_type    rsp_status_ff;
   logic [CW-1:0] rsp_aff_ff;
   logic [CW-1:0] rsp_occ_ff;
   logic [CW+6:0] aff_wide;
   logic [CW+6:0] occ_wide;

   logic [15:0] life_ff;

   // ram ports
   logic          ram_wr_en;
   logic [AW-1:0] ram_wr_addr;
   logic [WW-1:0] ram_wr_data;
   logic [WW-1:0] ram_rd_data;

   // fields of the entry coming out of the ram
   logic          ent_valid;
   logic          ent_hit;
   logic          ent_aged;
   logic [31:0]   ent_age;

   assign req_address = {req_address_high, req_address_low};

   aet_ram #(
      .WIDTH (WW),
      .DEPTH (CAPACITY)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (scan_rd),
      .rd_addr (cnt_ff),
      .rd_data (ram_rd_data)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         FSM_CLEAR: begin
            if (cnt_ff == LAST_IDX) state_in = FSM_IDLE;
         end
         FSM_IDLE: begin
            if (req_valid) begin
               state_in = (op_type'(req_operation) == OP_RESERVED) ? FSM_COMMIT : FSM_SCAN;
            end
         end
         FSM_SCAN: begin
            if (cnt_ff == LAST_IDX) state_in = FSM_LAST;
         end
         FSM_LAST:   state_in = FSM_COMMIT;
         FSM_COMMIT: state_in = FSM_DONE;
         FSM_DONE: begin
            if (rsp_free) state_in = FSM_IDLE;
         end
         default:    state_in = FSM_IDLE;
      endcase
   end

   // controller outputs
   always_comb begin
      req_stall = 1'b1;
      scan_rd   = 1'b0;
      cnt_step  = 1'b0;
      commit    = 1'b0;
      rsp_load  = 1'b0;
      unique case (state_ff)
         FSM_CLEAR:  cnt_step = 1'b1;
         FSM_IDLE:   req_stall = 1'b0;
         FSM_SCAN: begin
            scan_rd  = 1'b1;
            cnt_step = 1'b1;
         end
         FSM_LAST:   ;
         FSM_COMMIT: commit = 1'b1;
         FSM_DONE:   rsp_load = rsp_free;
         default:    ;
      endcase
   end

   assign req_xfer  = req_valid && !req_stall;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign csr_ready = 1'b1;

   // entry under inspection
   assign ent_valid = ram_rd_data[VALID_BIT];
   assign ent_hit   = ent_valid
                      && (ram_rd_data[VER_BIT] == ver_ff)
                      && (ram_rd_data[ADDR_LSB +: KW] == key_ff)
                      && (ram_rd_data[PORT_LSB +: PORT_W] == port_ff);
   // age wraps modulo 2^32
   assign ent_age   = now_ff - ram_rd_data[0 +: STAMP_W];
   assign ent_aged  = ent_valid && (ent_age > {16'd0, life_ff});

   // scan, write back and result
   always_comb begin
      cnt_in         = cnt_ff;
      match_found_in = match_found_ff;
      match_idx_in   = match_idx_ff;
      match_flags_in = match_flags_ff;
      free_found_in  = free_found_ff;
      free_idx_in    = free_idx_ff;
      aff_in         = aff_ff;
      occ_in         = occ_ff;
      res_status_in  = res_status_ff;
      res_aff_in     = res_aff_ff;
      ram_wr_en      = 1'b0;
      ram_wr_addr    = cnt_ff;
      ram_wr_data    = '0;

      if (req_xfer) begin
         cnt_in         = '0;
         match_found_in = 1'b0;
         free_found_in  = 1'b0;
         aff_in         = '0;
      end else if (cnt_step) begin
         cnt_in = AW'(cnt_ff + 1'b1);
      end

      priority if (state_ff == FSM_CLEAR) begin
         // sweep clears every valid bit
         ram_wr_en = 1'b1;
      end else if (rd_vld_ff) begin
         unique case (op_ff)
            OP_UPDATE: begin
               // remember first match and first free slot
               if (ent_hit && !match_found_ff) begin
                  match_found_in = 1'b1;
                  match_idx_in   = idx_ff;
                  match_flags_in = ram_rd_data[FLAGS_LSB +: FLAGS_W];
               end
               if (!ent_valid && !free_found_ff) begin
                  free_found_in = 1'b1;
                  free_idx_in   = idx_ff;
               end
            end
            OP_REMOVE, OP_CULL: begin
               if ((op_ff == OP_REMOVE) ? ent_hit : ent_aged) begin
                  ram_wr_en   = 1'b1;
                  ram_wr_addr = idx_ff;
                  ram_wr_data = ram_rd_data;
                  ram_wr_data[VALID_BIT] = 1'b0;
                  aff_in = CW'(aff_ff + 1'b1);
                  occ_in = CW'(occ_ff - 1'b1);
               end
            end
            OP_RESERVED: ;
            default:     ;
         endcase
      end else if (commit) begin
         unique case (op_ff)
            OP_UPDATE: begin
               if (match_found_ff) begin
                  ram_wr_en     = 1'b1;
                  ram_wr_addr   = match_idx_ff;
                  ram_wr_data   = {1'b1, ver_ff, key_ff, port_ff, match_flags_ff, now_ff};
                  res_status_in = ST_REFRESHED;
                  res_aff_in    = CW'(1);
               end else if (free_found_ff) begin
                  ram_wr_en     = 1'b1;
                  ram_wr_addr   = free_idx_ff;
                  ram_wr_data   = {1'b1, ver_ff, key_ff, port_ff, flags_ff, now_ff};
                  res_status_in = ST_INSERTED;
                  res_aff_in    = CW'(1);
                  occ_in        = CW'(occ_ff + 1'b1);
               end else begin
                  res_status_in = ST_DROPPED;
                  res_aff_in    = '0;
               end
            end
            OP_REMOVE: begin
               res_status_in = (aff_ff != '0) ? ST_REMOVED : ST_NOT_FOUND;
               res_aff_in    = aff_ff;
            end
            OP_CULL: begin
               res_status_in = ST_CULLED;
               res_aff_in    = aff_ff;
            end
            OP_RESERVED: begin
               res_status_in = ST_NOT_FOUND;
               res_aff_in    = '0;
            end
            default: ;
         endcase
      end else begin
         ram_wr_en = 1'b0;
      end
   end

   // output register takes the result when it is free
   always_comb begin
      priority if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= FSM_CLEAR;
         cnt_ff       <= '0;
         rd_vld_ff    <= 1'b0;
         occ_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         life_ff      <= LIFETIME_RESET;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rd_vld_ff    <= scan_rd;
         occ_ff       <= occ_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            life_ff <= csr_lifetime_seconds;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         op_ff    <= op_type'(req_operation);
         ver_ff   <= req_ip_version;
         key_ff   <= req_address[KW-1:0];
         port_ff  <= req_port_number;
         flags_ff <= {req_is_full, req_is_empty};
         now_ff   <= req_now_seconds;
      end
      idx_ff         <= cnt_ff;
      match_found_ff <= match_found_in;
      match_idx_ff   <= match_idx_in;
      match_flags_ff <= match_flags_in;
      free_found_ff  <= free_found_in;
      free_idx_ff    <= free_idx_in;
      aff_ff         <= aff_in;
      res_status_ff  <= res_status_in;
      res_aff_ff     <= res_aff_in;
      if (rsp_load) begin
         rsp_status_ff <= res_status_ff;
         rsp_aff_ff    <= res_aff_ff;
         rsp_occ_ff    <= occ_ff;
      end
   end

   // counts are reported in 7 bits
   assign aff_wide           = {7'd0, rsp_aff_ff};
   assign occ_wide           = {7'd0, rsp_occ_ff};
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_affected_count = aff_wide[6:0];
   assign rsp_occupancy      = occ_wide[6:0];

   // occupancy counter stays within the table
   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      occ_ff <= CAP_COUNT)
      else $error("occupancy count beyond capacity");

   // write back behind the scan never collides with the read in flight
   a_no_rw_collide: assert property (@(posedge clock) disable iff (reset)
      (ram_wr_en && scan_rd) |-> (ram_wr_addr != cnt_ff))
      else $error("ram write and read hit the same entry");

   // an insert only happens with room left
   a_insert_room: assert property (@(posedge clock) disable iff (reset)
      (commit && (op_ff == OP_UPDATE) && !match_found_ff && free_found_ff)
      |-> (occ_ff < CAP_COUNT))
      else $error("insert into a full table");

   // a removed status always reports at least one entry
   a_removed_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_status_ff == ST_REMOVED)) |-> (rsp_aff_ff != '0))
      else $error("removed status with zero count");

endmodule

[rtl/aet_ram.sv]
// aet_ram: generic single-clock ram, one write port and one registered read port.
// No dependencies.
module aet_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[verif/tb_aging_endpoint_table.sv]
// tb_aging_endpoint_table: self-checking bench for the aging endpoint table.
// Depends on aet_pkg and aging_endpoint_table; a directed table, then random
// update/remove/cull traffic with reserved codes, checked against an in-bench table model.
module tb_aging_endpoint_table import aet_pkg::*;;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CAPACITY      = 64;
   localparam int ADDRESS_BYTES = 16;
   localparam int POOL_SIZE     = 80;     // a little above capacity so fills overflow
   localparam int PHASE_ITEMS   = 425;
   localparam int NUM_PHASES    = 4;
   localparam longint LIMIT_NS  = 40_000_000;

   // only the low ADDRESS_BYTES of the address belong to the key
   localparam int LO_BITS = (ADDRESS_BYTES >= 8) ? 64 : ADDRESS_BYTES * 8;
   localparam int HI_BITS = (ADDRESS_BYTES > 8) ? (ADDRESS_BYTES - 8) * 8 : 0;
   localparam logic [63:0] LO_MASK = ~64'd0 >> (64 - LO_BITS);
   localparam logic [63:0] HI_MASK = (HI_BITS == 0) ? 64'd0 : ~64'd0 >> (64 - HI_BITS);

   typedef struct packed {
      logic        ver;
      logic [63:0] hi;
      logic [63:0] lo;
      logic [15:0] port;
   } endpoint_key_type;

   typedef struct packed {
      op_type           op;
      endpoint_key_type key;
      logic             empty;
      logic             full;
      logic [31:0]      now;
   } endpoint_req_type;

   typedef struct packed {
      status_type status;
      logic [6:0] count;
      logic [6:0] occ;
   } table_rsp_type;

   typedef struct packed {
      endpoint_req_type req;
      logic             fixed;   // expected result typed in by hand
      table_rsp_type    rsp;
   } directed_row_type;

   // shapes of random traffic
   typedef enum int {SEQ_FILL, SEQ_MIX, SEQ_DRAIN} seq_mode_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [1:0]  req_operation;
   logic        req_ip_version;
   logic [63:0] req_address_high;
   logic [63:0] req_address_low;
   logic [15:0] req_port_number;
   logic        req_is_empty;
   logic        req_is_full;
   logic [31:0] req_now_seconds;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [2:0]  rsp_status;
   logic [6:0]  rsp_affected_count;
   logic [6:0]  rsp_occupancy;
   logic        csr_valid;
   logic        csr_ready;
   logic [15:0] csr_lifetime_seconds;

   // shadow copy of the table and the lifetime register
   logic             tbl_valid [CAPACITY];
   endpoint_key_type tbl_key   [CAPACITY];
   logic [31:0]      tbl_stamp [CAPACITY];
   logic [15:0]      lifetime_model;

   endpoint_key_type key_pool [POOL_SIZE];
   directed_row_type directed_rows [$];
   table_rsp_type    expected_rsps [$];   // one per request transfer, oldest first
   logic [31:0]      cur_now;
   int               fill_ptr;
   int               burst_left;
   int               mismatch_count;

   aging_endpoint_table #(
      .CAPACITY      (CAPACITY),
      .ADDRESS_BYTES (ADDRESS_BYTES)
   ) i_dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_operation        (req_operation),
      .req_ip_version       (req_ip_version),
      .req_address_high     (req_address_high),
      .req_address_low      (req_address_low),
      .req_port_number      (req_port_number),
      .req_is_empty         (req_is_empty),
      .req_is_full          (req_is_full),
      .req_now_seconds      (req_now_seconds),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_status           (rsp_status),
      .rsp_affected_count   (rsp_affected_count),
      .rsp_occupancy        (rsp_occupancy),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_lifetime_seconds (csr_lifetime_seconds)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // hard stop in case the block hangs
   initial begin
      #LIMIT_NS;
      $display("end of test: mismatches");
      $finish;
   end

   function automatic bit key_hit(int i, endpoint_key_type k);
      return tbl_valid[i] && (tbl_key[i] == k);
   endfunction

   // applies one operation to the shadow table and returns its result
   function automatic table_rsp_type apply_to_table(endpoint_req_type r);
      table_rsp_type    o;
      endpoint_key_type k;
      int               slot;
      logic [31:0]      age;
      k        = r.key;
      k.hi     = k.hi & HI_MASK;
      k.lo     = k.lo & LO_MASK;
      o.status = ST_NOT_FOUND;
      o.count  = '0;
      o.occ    = '0;
      case (r.op)
         OP_UPDATE: begin
            slot = -1;
            for (int i = 0; i < CAPACITY; i++)
               if (slot < 0 && key_hit(i, k)) slot = i;
            if (slot >= 0) begin
               // known endpoint: only the stamp moves, flags stay
               tbl_stamp[slot] = r.now;
               o.status = ST_REFRESHED;
               o.count  = 7'd1;
            end else begin
               // new endpoint goes to the lowest free slot
               for (int i = 0; i < CAPACITY; i++)
                  if (slot < 0 && !tbl_valid[i]) slot = i;
               if (slot >= 0) begin
                  tbl_valid[slot] = 1'b1;
                  tbl_key[slot]   = k;
                  tbl_stamp[slot] = r.now;
                  o.status = ST_INSERTED;
                  o.count  = 7'd1;
               end else begin
                  o.status = ST_DROPPED;
               end
            end
         end
         OP_REMOVE: begin
            for (int i = 0; i < CAPACITY; i++)
               if (key_hit(i, k)) begin
                  tbl_valid[i] = 1'b0;
                  o.count++;
               end
            o.status = (o.count != 0) ? ST_REMOVED : ST_NOT_FOUND;
         end
         OP_CULL: begin
            // age wraps modulo 2^32; age equal to the lifetime survives
            for (int i = 0; i < CAPACITY; i++)
               if (tbl_valid[i]) begin
                  age = r.now - tbl_stamp[i];
                  if (age > {16'd0, lifetime_model}) begin
                     tbl_valid[i] = 1'b0;
                     o.count++;
                  end
               end
            o.status = ST_CULLED;
         end
         default: ;   // reserved code leaves the table alone
      endcase
      for (int i = 0; i < CAPACITY; i++)
         if (tbl_valid[i]) o.occ++;
      return o;
   endfunction

   function automatic endpoint_key_type mk_key(logic ver, logic [63:0] hi, logic [63:0] lo,
                                                logic [15:0] port);
      endpoint_key_type k;
      k.ver  = ver;
      k.hi   = hi;
      k.lo   = lo;
      k.port = port;
      return k;
   endfunction

   function automatic endpoint_key_type random_key();
      return mk_key(1'($urandom_range(0, 1)), {$urandom, $urandom}, {$urandom, $urandom},
                    16'($urandom_range(0, 65535)));
   endfunction

   task automatic add_row(op_type op, endpoint_key_type k, logic e, logic f, logic [31:0] now,
                          logic fixed, status_type st, logic [6:0] cnt, logic [6:0] occ);
      directed_row_type row;
      row.req.op     = op;
      row.req.key    = k;
      row.req.empty  = e;
      row.req.full   = f;
      row.req.now    = now;
      row.fixed      = fixed;
      row.rsp.status = st;
      row.rsp.count  = cnt;
      row.rsp.occ    = occ;
      directed_rows.push_back(row);
   endtask

   // one random request; the time base mostly creeps forward, now and then jumps
   function automatic endpoint_req_type random_req(seq_mode_type mode);
      endpoint_req_type r;
      int               pick;
      int               roll;
      pick = $urandom_range(0, 99);
      case (mode)
         SEQ_FILL:  r.op = OP_UPDATE;
         SEQ_MIX:   r.op = (pick < 50) ? OP_UPDATE : (pick < 75) ? OP_REMOVE :
                           (pick < 92) ? OP_CULL : OP_RESERVED;
         default:   r.op = (pick < 65) ? OP_REMOVE : (pick < 85) ? OP_CULL : OP_UPDATE;
      endcase
      if (mode == SEQ_FILL) begin
         r.key    = key_pool[fill_ptr];
         fill_ptr = (fill_ptr + 1) % POOL_SIZE;
      end else if ($urandom_range(0, 19) == 0) begin
         r.key = random_key();   // stray key, mostly misses
      end else begin
         r.key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
      end
      r.empty = 1'($urandom_range(0, 1));
      r.full  = 1'($urandom_range(0, 1));
      roll = $urandom_range(0, 99);
      if (roll < 4)
         cur_now = $urandom;
      else if (roll >= 10)
         cur_now += $urandom_range(0, lifetime_model / 3 + 3);
      if (r.op == OP_CULL)
         cur_now += $urandom_range(0, 2 * lifetime_model + 2);
      r.now = cur_now;
      return r;
   endfunction

   // sender: bursts of back-to-back transfers, mostly separated by idle gaps
   task automatic send_req(endpoint_req_type it, logic fixed, table_rsp_type fixed_rsp);
      table_rsp_type predicted;
      int            gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 20);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 90);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      req_operation    <= it.op;
      req_ip_version   <= it.key.ver;
      req_address_high <= it.key.hi;
      req_address_low  <= it.key.lo;
      req_port_number  <= it.key.port;
      req_is_empty     <= it.empty;
      req_is_full      <= it.full;
      req_now_seconds  <= it.now;
      req_valid        <= 1'b1;
      @(posedge clock);
      while (req_stall !== 1'b0) @(posedge clock);
      // transfer taken at this edge
      predicted = apply_to_table(it);
      if (fixed)
         expected_rsps.push_back(fixed_rsp);
      else
         expected_rsps.push_back(predicted);
      @(negedge clock);
   endtask

   // idle the request side until every result is back
   task automatic drain();
      req_valid  <= 1'b0;
      burst_left = 0;
      @(negedge clock);
      while (expected_rsps.size() != 0) @(negedge clock);
   endtask

   task automatic write_lifetime(logic [15:0] value);
      csr_valid            <= 1'b1;
      csr_lifetime_seconds <= value;
      @(posedge clock);
      while (csr_ready !== 1'b1) @(posedge clock);
      lifetime_model = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic report_field(string name, logic [6:0] want, logic [6:0] got);
      if (got !== want) begin
         $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
         mismatch_count++;
      end
   endtask

   // result checker: every response transfer against the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (expected_rsps.size() == 0) begin
            $display("%0t: unexpected result, expected none actual status %0d count %0d occ %0d",
                     $time, rsp_status, rsp_affected_count, rsp_occupancy);
            mismatch_count++;
         end else begin
            table_rsp_type want;
            want = expected_rsps.pop_front();
            report_field("status", {4'd0, want.status}, {4'd0, rsp_status});
            report_field("affected_count", want.count, rsp_affected_count);
            report_field("occupancy", want.occ, rsp_occupancy);
         end
      end
   end

   // receiver: stall pattern changes every so often, from none to solid
   initial begin
      int mode;
      int span;
      rsp_stall = 1'b0;
      forever begin
         mode = $urandom_range(0, 3);
         span = (mode == 3) ? $urandom_range(1, 120) : $urandom_range(20, 300);
         repeat (span) begin
            @(negedge clock);
            case (mode)
               0:       rsp_stall <= 1'b0;
               1:       rsp_stall <= ($urandom_range(0, 9) < 3);
               2:       rsp_stall <= ($urandom_range(0, 9) < 8);
               default: rsp_stall <= 1'b1;
            endcase
         end
      end
   end

   initial begin
      endpoint_key_type key_a, key_b, key_c, key_d, key_e, key_f;
      logic [15:0]      phase_lifetimes [NUM_PHASES];
      table_rsp_type    no_rsp;
      seq_mode_type     mode;
      int               len;
      int               sent;
      int               pick;

      reset                = 1'b1;
      req_valid            = 1'b0;
      req_operation        = OP_UPDATE;
      req_ip_version       = 1'b0;
      req_address_high     = '0;
      req_address_low      = '0;
      req_port_number      = '0;
      req_is_empty         = 1'b0;
      req_is_full          = 1'b0;
      req_now_seconds      = '0;
      csr_valid            = 1'b0;
      csr_lifetime_seconds = '0;
      mismatch_count       = 0;
      burst_left           = 0;
      fill_ptr             = 0;
      cur_now              = $urandom;
      no_rsp               = '0;
      lifetime_model       = LIFETIME_RESET;
      for (int i = 0; i < CAPACITY; i++) begin
         tbl_valid[i] = 1'b0;
         tbl_key[i]   = '0;
         tbl_stamp[i] = '0;
      end

      // key pool: every fourth key is a one-bit neighbor of the one before it
      for (int k = 0; k < POOL_SIZE; k++) begin
         if (k % 4 == 3) begin
            key_pool[k] = key_pool[k - 1];
            case ($urandom_range(0, 3))
               0:       key_pool[k].ver  = ~key_pool[k].ver;
               1:       key_pool[k].hi   = key_pool[k].hi ^ (64'd1 << $urandom_range(0, 63));
               2:       key_pool[k].lo   = key_pool[k].lo ^ (64'd1 << $urandom_range(0, 63));
               default: key_pool[k].port = key_pool[k].port ^ (16'd1 << $urandom_range(0, 15));
            endcase
         end else begin
            key_pool[k] = random_key();
         end
      end

      key_a = mk_key(1'b0, 64'd0, 64'd0, 16'd0);
      key_b = mk_key(1'b1, ~64'd0, ~64'd0, 16'hFFFF);
      key_c = mk_key(1'b1, 64'd0, 64'd0, 16'd0);           // a with other version
      key_d = mk_key(1'b0, 64'd0, 64'd0, 16'd1);           // a with other port
      key_e = mk_key(1'b1, 64'h8000_0000_0000_0000, 64'd1, 16'h8000);
      key_f = mk_key(1'b0, 64'd1, 64'h8000_0000_0000_0000, 16'h7FFF);

      // empty table after reset, then extremes and the single-field key variants
      add_row(OP_REMOVE,   key_a, 0, 0, 32'd0,        1, ST_NOT_FOUND, 7'd0, 7'd0);
      add_row(OP_CULL,     key_a, 0, 0, 32'd0,        1, ST_CULLED,    7'd0, 7'd0);
      add_row(OP_RESERVED, key_b, 1, 1, ~32'd0,       1, ST_NOT_FOUND, 7'd0, 7'd0);
      add_row(OP_UPDATE,   key_a, 0, 0, 32'd0,        1, ST_INSERTED,  7'd1, 7'd1);
      add_row(OP_UPDATE,   key_b, 1, 1, ~32'd0,       1, ST_INSERTED,  7'd1, 7'd2);
      add_row(OP_UPDATE,   key_a, 1, 1, 32'd100,      1, ST_REFRESHED, 7'd1, 7'd2);
      add_row(OP_UPDATE,   key_c, 0, 1, 32'd50,       0, ST_INSERTED,  7'd0, 7'd0);
      add_row(OP_UPDATE,   key_d, 1, 0, 32'd100,      0, ST_INSERTED,  7'd0, 7'd0);
      add_row(OP_REMOVE,   key_b, 0, 0, 32'd100,      0, ST_REMOVED,   7'd0, 7'd0);
      add_row(OP_REMOVE,   key_b, 0, 0, 32'd100,      0, ST_NOT_FOUND, 7'd0, 7'd0);
      // reset lifetime: age equal to the lifetime is kept, one more second culls
      add_row(OP_CULL,     key_a, 0, 0, 32'd400,      0, ST_CULLED,    7'd0, 7'd0);
      add_row(OP_CULL,     key_a, 0, 0, 32'd401,      0, ST_CULLED,    7'd0, 7'd0);
      // stamps just below the wrap, key_e culled after now rolls over, key_f removed
      add_row(OP_UPDATE,   key_e, 1, 0, 32'hFFFF_FF00, 0, ST_INSERTED, 7'd0, 7'd0);
      add_row(OP_UPDATE,   key_f, 0, 1, 32'hFFFF_FFF0, 0, ST_INSERTED, 7'd0, 7'd0);
      add_row(OP_CULL,     key_a, 0, 0, 32'h0000_0010, 0, ST_CULLED,   7'd0, 7'd0);
      add_row(OP_CULL,     key_a, 0, 0, 32'h0000_0030, 0, ST_CULLED,   7'd0, 7'd0);
      add_row(OP_RESERVED, key_f, 1, 1, 32'h0000_0030, 0, ST_NOT_FOUND, 7'd0, 7'd0);
      add_row(OP_REMOVE,   key_f, 0, 0, 32'h0000_0030, 0, ST_REMOVED,  7'd0, 7'd0);
      add_row(OP_CULL,     key_a, 0, 0, ~32'd0,       0, ST_CULLED,    7'd0, 7'd0);

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // the clearing sweep after reset holds req_stall, the driver waits it out
      foreach (directed_rows[r])
         send_req(directed_rows[r].req, directed_rows[r].fixed, directed_rows[r].rsp);
      drain();

      phase_lifetimes[0] = 16'd0;
      phase_lifetimes[1] = 16'hFFFF;
      phase_lifetimes[2] = 16'($urandom_range(1, 65534));
      phase_lifetimes[3] = 16'($urandom_range(0, 40));

      for (int p = 0; p < NUM_PHASES; p++) begin
         write_lifetime(phase_lifetimes[p]);
         sent = 0;
         while (sent < PHASE_ITEMS) begin
            pick = $urandom_range(0, 9);
            if (pick < 3) begin
               // long runs of inserts push the table into overflow
               mode = SEQ_FILL;
               len  = $urandom_range(66, 90);
            end else begin
               mode = (pick < 7) ? SEQ_MIX : SEQ_DRAIN;
               len  = $urandom_range(10, 40);
            end
            repeat (len) begin
               send_req(random_req(mode), 1'b0, no_rsp);
               sent++;
            end
         end
         drain();
      end

      // let any stray result show up before judging
      repeat (CAPACITY + 8) @(posedge clock);
      if (mismatch_count == 0 && expected_rsps.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

[aging_endpoint_table.f]
rtl/aet_pkg.sv
rtl/aet_ram.sv
rtl/aging_endpoint_table.sv
verif/tb_aging_endpoint_table.sv
